@@ rtl/core/scmd_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// scmd_pkg
// Shared types and constants for the spindle command line parser.
// ============================================================================
package scmd_pkg;

    localparam int MAG_W   = 40;
    localparam int SPEED_W = 41;

    localparam logic [MAG_W-1:0] MAG_LIMIT = {MAG_W{1'b1}};
    localparam logic [MAG_W-1:0] MAG_TENTH = MAG_LIMIT / 10;

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_M     = 8'h4D;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD      = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;

    localparam logic [1:0] DIR_OFF = 2'd0;
    localparam logic [1:0] DIR_CW  = 2'd1;
    localparam logic [1:0] DIR_CCW = 2'd2;

    // M code windows on the value scaled by 1000
    localparam logic [MAG_W-1:0] M3_LO  = MAG_W'(3000);
    localparam logic [MAG_W-1:0] M4_LO  = MAG_W'(4000);
    localparam logic [MAG_W-1:0] M5_LO  = MAG_W'(5000);
    localparam logic [MAG_W-1:0] M6_LO  = MAG_W'(6000);
    localparam logic [MAG_W-1:0] M19_LO = MAG_W'(19000);
    localparam logic [MAG_W-1:0] M20_LO = MAG_W'(20000);

    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_LETTER  = 5'b00010,
        MODE_INT     = 5'b00100,
        MODE_FRAC    = 5'b01000,
        MODE_DISCARD = 5'b10000
    } t_parse_mode;

endpackage

@@ rtl/core/scmd_digit_acc.sv @@
`timescale 1ns / 1ps
// ============================================================================
// scmd_digit_acc
// Saturating decimal accumulate step for one value digit, integer or fraction.
// ============================================================================
module scmd_digit_acc
    import scmd_pkg::*;
(
    input  logic [MAG_W-1:0] i_accum,
    input  logic [3:0]       i_digit,
    input  logic             i_frac,
    input  logic [1:0]       i_frac_digits,
    output logic [MAG_W-1:0] o_accum,
    output logic [1:0]       o_frac_digits
);

    logic [MAG_W+3:0] times_ten;
    logic [MAG_W-1:0] base;
    logic [13:0]      amount;
    logic [MAG_W:0]   sum;

    always_comb begin
        times_ten     = {1'b0, i_accum, 3'b000} + {3'b000, i_accum, 1'b0};
        base          = i_accum;
        amount        = '0;
        o_frac_digits = i_frac_digits;
        if (i_frac) begin
            if (i_frac_digits != 2'd3) begin
                o_frac_digits = i_frac_digits + 2'd1;
                case (i_frac_digits)
                    2'd0:    amount = 14'(i_digit) * 14'd100;
                    2'd1:    amount = 14'(i_digit) * 14'd10;
                    default: amount = 14'(i_digit);
                endcase
            end
        end else begin
            base   = (i_accum > MAG_TENTH) ? MAG_LIMIT : times_ten[MAG_W-1:0];
            amount = 14'(i_digit) * 14'd1000;
        end
        sum     = {1'b0, base} + (MAG_W+1)'(amount);
        o_accum = sum[MAG_W] ? MAG_LIMIT : sum[MAG_W-1:0];
    end

endmodule

@@ rtl/core/spindle_command_line_parser.sv @@
`timescale 1ns / 1ps
// ============================================================================
// spindle_command_line_parser
// Parses command-line characters into speed, direction and orientation words.
// ============================================================================
// A carriage return transfer reaches its status transfer through the input register,
// then the result register.
// Throughput: one character per cycle while o_stall is low, set by the parse stage.
// A stalled status blocks only a following carriage return at the input stage.
// Reset (synchronous, active low) clears parse state, speed and direction.
module spindle_command_line_parser
    import scmd_pkg::*;
#(
    parameter int MAX_VALUE_CHARS = 9
)(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_char_in,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic signed [40:0] o_target_speed_milli,
    output logic [1:0]         o_direction,
    output logic               o_orient_request
);

    logic [7:0] folded;
    logic       in_accept;
    logic       proc_en;

    logic       r_in_valid;
    logic [7:0] r_in_char;

    t_parse_mode         r_mode, n_mode;
    logic [7:0]          r_letter, n_letter;
    logic [MAG_W-1:0]    r_accum, n_accum;
    logic                r_neg, n_neg;
    logic [1:0]          r_frac_digits, n_frac_digits;
    logic                r_ended, n_ended;
    logic [3:0]          r_len, n_len;
    logic [1:0]          r_err, n_err;
    logic [SPEED_W-1:0]  r_speed, n_speed;
    logic [1:0]          r_dir, n_dir;
    logic                r_orient, n_orient;

    logic                r_out_valid, n_out_valid;
    logic [1:0]          r_out_status, n_out_status;
    logic [SPEED_W-1:0]  r_out_speed, n_out_speed;
    logic [1:0]          r_out_dir, n_out_dir;
    logic                r_out_orient, n_out_orient;

    logic               is_cr, is_letter, is_digit;
    logic [MAG_W-1:0]   dig_accum;
    logic [1:0]         dig_frac;
    logic [SPEED_W-1:0] word_value;
    logic               word_speed, word_m;

    assign folded    = (i_char_in >= CH_LA && i_char_in <= CH_LZ) ? i_char_in - 8'd32
                                                                   : i_char_in;
    assign o_stall   = r_in_valid && (r_in_char == CH_CR) && r_out_valid && i_stall;
    assign in_accept = i_valid && !o_stall;
    assign proc_en   = r_in_valid && !o_stall;

    assign is_cr     = (r_in_char == CH_CR);
    assign is_letter = (r_in_char >= CH_A) && (r_in_char <= CH_Z);
    assign is_digit  = (r_in_char >= CH_0) && (r_in_char <= CH_9);

    assign word_value = r_neg ? -{1'b0, r_accum} : {1'b0, r_accum};
    assign word_speed = (r_letter == CH_S) || (r_letter == CH_F);
    assign word_m     = (r_letter == CH_M) && !r_neg;

    scmd_digit_acc u_digit (
        .i_accum       (r_accum),
        .i_digit       (r_in_char[3:0]),
        .i_frac        (r_mode == MODE_FRAC),
        .i_frac_digits (r_frac_digits),
        .o_accum       (dig_accum),
        .o_frac_digits (dig_frac)
    );

    always_comb begin
        n_mode        = r_mode;
        n_letter      = r_letter;
        n_accum       = r_accum;
        n_neg         = r_neg;
        n_frac_digits = r_frac_digits;
        n_ended       = r_ended;
        n_len         = r_len;
        n_err         = r_err;
        n_speed       = r_speed;
        n_dir         = r_dir;
        n_orient      = r_orient;
        n_out_valid   = r_out_valid && i_stall;
        n_out_status  = r_out_status;
        n_out_speed   = r_out_speed;
        n_out_dir     = r_out_dir;
        n_out_orient  = r_out_orient;

        if (proc_en) begin
            if (is_cr) begin
                if (r_mode == MODE_LETTER) begin
                    if (r_err == ST_OK) begin
                        n_err = ST_BAD;
                    end
                end else if (r_mode == MODE_INT || r_mode == MODE_FRAC) begin
                    if (word_speed) begin
                        n_speed = word_value;
                    end else if (word_m) begin
                        if (r_accum >= M3_LO && r_accum < M4_LO) n_dir = DIR_CW;
                        else if (r_accum >= M4_LO && r_accum < M5_LO) n_dir = DIR_CCW;
                        else if (r_accum >= M5_LO && r_accum < M6_LO) n_dir = DIR_OFF;
                        else if (r_accum >= M19_LO && r_accum < M20_LO) n_orient = 1'b1;
                    end
                end
                n_out_valid   = 1'b1;
                n_out_status  = n_err;
                n_out_speed   = n_speed;
                n_out_dir     = n_dir;
                n_out_orient  = n_orient;
                n_mode        = MODE_IDLE;
                n_letter      = '0;
                n_accum       = '0;
                n_neg         = 1'b0;
                n_frac_digits = '0;
                n_ended       = 1'b0;
                n_len         = '0;
                n_err         = ST_OK;
                n_orient      = 1'b0;
            end else if (r_in_char != CH_SPACE) begin
                unique case (r_mode)
                    MODE_DISCARD: begin
                    end
                    MODE_IDLE: begin
                        if (is_letter) begin
                            n_letter      = r_in_char;
                            n_accum       = '0;
                            n_neg         = 1'b0;
                            n_frac_digits = '0;
                            n_ended       = 1'b0;
                            n_len         = '0;
                            n_mode        = MODE_LETTER;
                        end
                    end
                    MODE_LETTER, MODE_INT, MODE_FRAC: begin
                        if (is_letter) begin
                            if (r_mode == MODE_LETTER) begin
                                if (r_err == ST_OK) n_err = ST_BAD;
                                n_mode = MODE_DISCARD;
                            end else begin
                                if (word_speed) begin
                                    n_speed = word_value;
                                end else if (word_m) begin
                                    if (r_accum >= M3_LO && r_accum < M4_LO) n_dir = DIR_CW;
                                    else if (r_accum >= M4_LO && r_accum < M5_LO)
                                        n_dir = DIR_CCW;
                                    else if (r_accum >= M5_LO && r_accum < M6_LO)
                                        n_dir = DIR_OFF;
                                    else if (r_accum >= M19_LO && r_accum < M20_LO)
                                        n_orient = 1'b1;
                                end
                                n_letter      = r_in_char;
                                n_accum       = '0;
                                n_neg         = 1'b0;
                                n_frac_digits = '0;
                                n_ended       = 1'b0;
                                n_len         = '0;
                                n_mode        = MODE_LETTER;
                            end
                        end else if (is_digit || r_in_char == CH_DOT
                                     || r_in_char == CH_MINUS) begin
                            if (r_len >= 4'(MAX_VALUE_CHARS)) begin
                                if (r_err == ST_OK) n_err = ST_TOO_LONG;
                                n_mode = MODE_DISCARD;
                            end else begin
                                n_len = r_len + 4'd1;
                                if (!r_ended) begin
                                    if (r_in_char == CH_MINUS) begin
                                        if (r_len == 4'd0) n_neg = 1'b1;
                                        else n_ended = 1'b1;
                                    end else if (r_in_char == CH_DOT) begin
                                        if (r_mode == MODE_FRAC) n_ended = 1'b1;
                                        else n_mode = MODE_FRAC;
                                    end else begin
                                        n_accum       = dig_accum;
                                        n_frac_digits = dig_frac;
                                    end
                                    if (r_mode == MODE_LETTER && n_mode == MODE_LETTER) begin
                                        n_mode = MODE_INT;
                                    end
                                end
                            end
                        end else begin
                            if (r_err == ST_OK) n_err = ST_BAD;
                            n_mode = MODE_DISCARD;
                        end
                    end
                    default: begin
                        n_mode = MODE_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_mode        <= MODE_IDLE;
            r_letter      <= '0;
            r_accum       <= '0;
            r_neg         <= 1'b0;
            r_frac_digits <= '0;
            r_ended       <= 1'b0;
            r_len         <= '0;
            r_err         <= ST_OK;
            r_speed       <= '0;
            r_dir         <= DIR_OFF;
            r_orient      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (proc_en) begin
                r_in_valid <= 1'b0;
            end
            r_mode        <= n_mode;
            r_letter      <= n_letter;
            r_accum       <= n_accum;
            r_neg         <= n_neg;
            r_frac_digits <= n_frac_digits;
            r_ended       <= n_ended;
            r_len         <= n_len;
            r_err         <= n_err;
            r_speed       <= n_speed;
            r_dir         <= n_dir;
            r_orient      <= n_orient;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_char <= folded;
        end
        r_out_status <= n_out_status;
        r_out_speed  <= n_out_speed;
        r_out_dir    <= n_out_dir;
        r_out_orient <= n_out_orient;
    end

    assign o_valid              = r_out_valid;
    assign o_status             = r_out_status;
    assign o_target_speed_milli = r_out_speed;
    assign o_direction          = r_out_dir;
    assign o_orient_request     = r_out_orient;

endmodule

@@ sim/spindle_command_line_parser_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// spindle_command_line_parser_tb
// Streams command-line characters into the parser and checks every line
// status against a cycle-free model of the word parser: speed words, M codes,
// value scaling and truncation, spaces, stray characters and all error kinds.
// Both sides idle at random, the receiver holds off once for a long stretch,
// and the sender drains between phases.
// ============================================================================
module spindle_command_line_parser_tb;
    import scmd_pkg::*;

    localparam int MAX_CHARS      = 9;
    localparam int RANDOM_CHARS   = 1150;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 300;
    localparam int HOLD_AT_RESULT = 20;

    localparam int M_CW     = 3;
    localparam int M_CCW    = 4;
    localparam int M_STOP   = 5;
    localparam int M_ORIENT = 19;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [40:0] speed;
        logic [1:0]         dir;
        logic               orient;
    } t_line_status;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic [7:0]         i_char_in = 8'd0;
    logic               i_stall = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic [1:0]         o_status;
    logic signed [40:0] o_target_speed_milli;
    logic [1:0]         o_direction;
    logic               o_orient_request;

    spindle_command_line_parser #(
        .MAX_VALUE_CHARS(MAX_CHARS)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_char_in(i_char_in),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_status(o_status),
        .o_target_speed_milli(o_target_speed_milli),
        .o_direction(o_direction),
        .o_orient_request(o_orient_request)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [7:0]   cmd_chars_q[$];
    t_line_status pending_status_q[$];
    int n_queued  = 0;
    int n_sent    = 0;
    int n_results = 0;
    int n_fail    = 0;
    int cyc       = 0;
    int idle_cycles = 0;

    wire calm = (cyc >= 600 && cyc < 1000);

    // line model state
    t_parse_mode        p_mode   = MODE_IDLE;
    logic [7:0]         p_letter = 8'd0;
    logic [MAG_W-1:0]   p_mag    = '0;
    logic               p_neg    = 1'b0;
    int                 p_frac   = 0;
    logic               p_ended  = 1'b0;
    int                 p_len    = 0;
    logic [1:0]         p_err    = ST_OK;
    logic signed [40:0] p_speed  = '0;
    logic [1:0]         p_dir    = DIR_OFF;
    logic               p_orient = 1'b0;

    function automatic logic [MAG_W-1:0] sat_add(input logic [MAG_W-1:0] a,
                                                 input logic [MAG_W-1:0] b);
        return (a > MAG_LIMIT - b) ? MAG_LIMIT : a + b;
    endfunction

    task automatic begin_word(input logic [7:0] letter);
        p_letter = letter;
        p_mag    = '0;
        p_neg    = 1'b0;
        p_frac   = 0;
        p_ended  = 1'b0;
        p_len    = 0;
        p_mode   = MODE_LETTER;
    endtask

    task automatic flag_error(input logic [1:0] code);
        if (p_err == ST_OK) p_err = code;
        p_mode = MODE_DISCARD;
    endtask

    task automatic commit_word();
        logic [MAG_W-1:0] code;
        if (p_letter == CH_S || p_letter == CH_F) begin
            p_speed = p_neg ? -$signed({1'b0, p_mag}) : $signed({1'b0, p_mag});
        end else if (p_letter == CH_M && !p_neg) begin
            code = p_mag / 1000;
            if (code == M_CW) p_dir = DIR_CW;
            else if (code == M_CCW) p_dir = DIR_CCW;
            else if (code == M_STOP) p_dir = DIR_OFF;
            else if (code == M_ORIENT) p_orient = 1'b1;
        end
    endtask

    task automatic parse_char(input logic [7:0] raw);
        logic [7:0]       ch;
        logic             is_letter;
        logic             is_digit;
        logic [MAG_W-1:0] digit;
        t_line_status     rec;
        ch = raw;
        if (ch >= CH_LA && ch <= CH_LZ) ch = ch - (CH_LA - CH_A);
        is_letter = (ch >= CH_A && ch <= CH_Z);
        is_digit  = (ch >= CH_0 && ch <= CH_9);
        digit     = MAG_W'(ch - CH_0);
        if (ch == CH_CR) begin
            if (p_mode == MODE_LETTER) flag_error(ST_BAD);
            else if (p_mode == MODE_INT || p_mode == MODE_FRAC) commit_word();
            rec.status = p_err;
            rec.speed  = p_speed;
            rec.dir    = p_dir;
            rec.orient = p_orient;
            pending_status_q.push_back(rec);
            begin_word(8'd0);
            p_mode   = MODE_IDLE;
            p_err    = ST_OK;
            p_orient = 1'b0;
        end else if (ch == CH_SPACE || p_mode == MODE_DISCARD) begin
        end else if (p_mode == MODE_IDLE) begin
            if (is_letter) begin_word(ch);
        end else if (is_letter) begin
            if (p_mode == MODE_LETTER) begin
                flag_error(ST_BAD);
            end else begin
                commit_word();
                begin_word(ch);
            end
        end else if (is_digit || ch == CH_DOT || ch == CH_MINUS) begin
            if (p_len >= MAX_CHARS) begin
                flag_error(ST_TOO_LONG);
            end else begin
                p_len++;
                if (!p_ended) begin
                    if (ch == CH_MINUS) begin
                        if (p_len == 1) p_neg = 1'b1;
                        else p_ended = 1'b1;
                    end else if (ch == CH_DOT) begin
                        if (p_mode == MODE_FRAC) p_ended = 1'b1;
                        else p_mode = MODE_FRAC;
                    end else if (p_mode == MODE_FRAC) begin
                        if (p_frac < 3) begin
                            p_mag = sat_add(p_mag, digit * ((p_frac == 0) ? 100 :
                                                            (p_frac == 1) ? 10 : 1));
                            p_frac++;
                        end
                    end else begin
                        p_mag = (p_mag > MAG_TENTH) ? MAG_LIMIT : p_mag * 10;
                        p_mag = sat_add(p_mag, digit * 1000);
                    end
                    if (p_mode == MODE_LETTER) p_mode = MODE_INT;
                end
            end
        end else begin
            flag_error(ST_BAD);
        end
    endtask

    // sender
    always @(posedge i_clk) begin : sender
        logic take;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                parse_char(i_char_in);
                n_sent++;
            end
            if (!(i_valid && o_stall)) begin
                take = cmd_chars_q.size() != 0 && (calm || $urandom_range(0, 99) >= 19);
                if (take) begin
                    i_char_in <= cmd_chars_q.pop_front();
                    i_valid   <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin : receiver
        t_line_status want;
        int hold_left;
        logic hold_done;
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                n_results++;
                if (pending_status_q.size() == 0) begin
                    $error("line status without a pending carriage return");
                    n_fail++;
                end else begin
                    want = pending_status_q.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, o_status);
                        n_fail++;
                    end
                    if (o_target_speed_milli !== want.speed) begin
                        $error("target_speed_milli: expected %0d, actual %0d",
                               want.speed, o_target_speed_milli);
                        n_fail++;
                    end
                    if (o_direction !== want.dir) begin
                        $error("direction: expected %0d, actual %0d", want.dir, o_direction);
                        n_fail++;
                    end
                    if (o_orient_request !== want.orient) begin
                        $error("orient_request: expected %0d, actual %0d",
                               want.orient, o_orient_request);
                        n_fail++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (!hold_done && n_results >= HOLD_AT_RESULT) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !calm && $urandom_range(0, 99) < 19;
            end
        end
    end

    // watchdog on transfers
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_char(input logic [7:0] c);
        cmd_chars_q.push_back(c);
        n_queued++;
    endtask

    task automatic push_text(input string s);
        for (int k = 0; k < s.len(); k++) push_char(s[k]);
    endtask

    task automatic push_line(input string s);
        push_text(s);
        push_char(CH_CR);
    endtask

    task automatic push_digits(input int n);
        repeat (n) push_char(CH_0 + 8'($urandom_range(0, 9)));
    endtask

    task automatic add_random_line();
        int kind;
        int pick;
        int m_codes[4];
        logic [7:0] letter;
        m_codes = '{M_CW, M_CCW, M_STOP, M_ORIENT};
        kind = $urandom_range(0, 99);
        if (kind < 6) begin
            repeat ($urandom_range(1, 12)) push_char(8'($urandom_range(0, 255)));
        end else if (kind < 9) begin
            repeat ($urandom_range(0, 3)) push_char(CH_A + 8'($urandom_range(0, 25)));
        end else begin
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(0, 9) == 0) push_char(CH_SPACE);
                if ($urandom_range(0, 19) == 0) push_char(8'($urandom_range(0, 255)));
                pick = $urandom_range(0, 9);
                letter = (pick < 3) ? CH_S : (pick < 4) ? CH_F : (pick < 7) ? CH_M :
                         CH_A + 8'($urandom_range(0, 25));
                if ($urandom_range(0, 3) == 0) letter = letter + (CH_LA - CH_A);
                push_char(letter);
                if (pick >= 4 && pick < 7 && $urandom_range(0, 2) != 0) begin
                    if ($urandom_range(0, 9) == 0) push_char(CH_MINUS);
                    push_text($sformatf("%0d", m_codes[$urandom_range(0, 3)]));
                    if ($urandom_range(0, 3) == 0) begin
                        push_char(CH_DOT);
                        push_digits($urandom_range(0, 3));
                    end
                end else if ($urandom_range(0, 29) != 0) begin
                    if ($urandom_range(0, 4) == 0) push_char(CH_MINUS);
                    push_digits(($urandom_range(0, 19) == 0) ? $urandom_range(5, 10) :
                                                               $urandom_range(0, 4));
                    if ($urandom_range(0, 1) == 0) begin
                        push_char(CH_DOT);
                        push_digits($urandom_range(0, 5));
                    end
                    if ($urandom_range(0, 14) == 0) begin
                        push_char(($urandom_range(0, 1) == 0) ? CH_DOT : CH_MINUS);
                        push_digits($urandom_range(0, 3));
                    end
                    if ($urandom_range(0, 14) == 0) begin
                        push_char(CH_SPACE);
                        push_digits($urandom_range(1, 2));
                    end
                end
            end
        end
        push_char(CH_CR);
    endtask

    task automatic drain_all();
        while (cmd_chars_q.size() != 0 || i_valid || pending_status_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        int start_count;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        push_line("S999999999");
        push_line("m3 f-99999999");
        push_line("#S12.3456M4");
        push_line("M19.7 S-1-2.3");
        push_line("S5.5.5x");
        push_line("S1234567890");
        push_line("M5 S7,M3");
        push_line("SM4");
        push_line("");
        push_line("S-");
        drain_all();

        start_count = n_queued;
        while (n_queued < start_count + RANDOM_CHARS / 2) add_random_line();
        drain_all();
        while (n_queued < start_count + RANDOM_CHARS) add_random_line();
        drain_all();

        $display("summary: %0d characters transferred, %0d line results checked,",
                 n_sent, n_results);
        $display("summary: %0d mismatches after directed, random and back-pressure phases",
                 n_fail);
        if (n_fail == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
